/* rtl/core/hgc_pkg.sv */
// ============================================================================
// hgc_pkg: shared types and constants of the horizontal gradient color unit
// Field widths, register indexes, the divider stage record and the channel
// blend function.
// ============================================================================
`default_nettype none

package hgc_pkg;

    // Largest span width that the unit honors; wider settings saturate.
    localparam int unsigned MAX_SPAN = 4096;

    localparam int unsigned COLUMN_W = 12;
    localparam int unsigned WIDTH_W  = 13;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned CHAN_W   = 8;
    // column * 255 needs 12 + 8 bits.
    localparam int unsigned NUM_W    = COLUMN_W + CHAN_W;
    // The weight never exceeds 255, so the quotient has one bit per divider stage.
    localparam int unsigned QUO_W    = CHAN_W;

    // Saturation point for the 13-bit width register.
    localparam logic [WIDTH_W-1:0] SPAN_CAP =
        WIDTH_W'((MAX_SPAN > 8191) ? 8191 : MAX_SPAN);

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_COLOR  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_COLOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPAN_WIDTH  = 2'd2;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } hgc_div_t;

    // (left * (255 - t) + right * t) >> 8; the sum stays below 2^16.
    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0] lc,
        input logic [CHAN_W-1:0] rc,
        input logic [CHAN_W-1:0] t
    );
        logic [15:0] sum;
        sum = 16'(lc) * 16'(8'd255 - t) + 16'(rc) * 16'(t);
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/horizontal_gradient_color_unit.sv */
// ============================================================================
// horizontal_gradient_color_unit
// Gives the color of one column of a horizontal gradient span, blending the
// left and right edge colors by a weight of column * 255 / (width - 1).
// ============================================================================
//
//  Channel  Ports                          Payload
//  -------  -----------------------------  ------------------------------
//  input    s_tvalid / s_tready / s_tdata  column in [11:0]
//  result   m_tvalid / m_tready / m_tdata  color in [23:0]
//  config   cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  One request is taken every cycle unless a result-side stall backs up to
//  stage 0; there are ten register stages: one stage clamps the column and
//  forms column * 255, eight restoring-division stages each settle one
//  weight bit, and one stage blends the three channels. Reset clears all
//  valid bits and loads the configuration registers with their reset values.
//  A stall on the result side holds each occupied stage whose successor is
//  also held; empty stages still fill, so bubbles are squeezed out.
//
`default_nettype none

module horizontal_gradient_color_unit
    import hgc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,    // [11:0] column

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,    // [23:0] color

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]     cfg_data
);

    localparam int NUM_DIV = QUO_W;
    localparam int LAST    = NUM_DIV + 1;

    logic [COLOR_W-1:0] left_color_reg;
    logic [COLOR_W-1:0] right_color_reg;
    logic [WIDTH_W-1:0] span_width_reg;

    logic [WIDTH_W-1:0] width_eff;
    logic [WIDTH_W-1:0] width_m1;
    logic [WIDTH_W-1:0] divisor;

    logic [COLUMN_W-1:0] column;
    logic [COLUMN_W-1:0] column_clamped;

    logic [LAST:0]   valid_reg;
    logic [LAST:0]   valid_next;
    logic [LAST+1:0] stage_ready;

    hgc_div_t div_reg  [NUM_DIV+1];
    hgc_div_t div_next [NUM_DIV+1];

    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_color_reg  <= '0;
            right_color_reg <= '0;
            span_width_reg  <= WIDTH_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LEFT_COLOR:  left_color_reg  <= cfg_data;
                REG_RIGHT_COLOR: right_color_reg <= cfg_data;
                REG_SPAN_WIDTH:  span_width_reg  <= cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // The user must change the registers only while the pipeline is empty; the
    // block does not enforce this. Then every stage may read them directly.
    always_comb begin
        if (span_width_reg == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (span_width_reg > SPAN_CAP) begin
            width_eff = SPAN_CAP;
        end else begin
            width_eff = span_width_reg;
        end
        width_m1 = width_eff - WIDTH_W'(1);
        divisor  = (width_m1 == '0) ? WIDTH_W'(1) : width_m1;
    end

    // A column past the span takes the last column; the clamped value then
    // fits in the column width.
    assign column = s_tdata[COLUMN_W-1:0];
    assign column_clamped = ({1'b0, column} > width_m1) ? width_m1[COLUMN_W-1:0] : column;

    // Handshake chain: a stage loads when it is empty or its successor loads.
    always_comb begin
        stage_ready[LAST+1] = m_tready;
        for (int i = LAST; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        valid_next[0] = stage_ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i <= LAST; i++) begin
            if (stage_ready[i]) begin
                valid_next[i] = valid_reg[i-1];
            end else begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    assign s_tready = stage_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage 0: numerator column * 255.
    always_comb begin
        div_next[0].rem = NUM_W'(column_clamped) * NUM_W'(255);
        div_next[0].quo = '0;
    end

    // Stages 1..8: one restoring-division step each, most significant bit
    // first. The shifted divisor never exceeds the numerator width.
    for (genvar j = 1; j <= NUM_DIV; j++) begin : g_div
        localparam int SHIFT = NUM_DIV - j;
        logic [NUM_W-1:0] dshift;
        logic             take;

        always_comb begin
            dshift = NUM_W'(divisor) << SHIFT;
            take   = (div_reg[j-1].rem >= dshift);
            div_next[j].rem = take ? (div_reg[j-1].rem - dshift) : div_reg[j-1].rem;
            div_next[j].quo = {div_reg[j-1].quo[QUO_W-2:0], take};
        end
    end

    for (genvar j = 0; j <= NUM_DIV; j++) begin : g_div_reg
        always_ff @(posedge aclk) begin
            if (stage_ready[j]) begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // Last stage: blend each channel by the weight.
    always_comb begin
        color_next[23:16] = blend_chan(left_color_reg[23:16], right_color_reg[23:16],
                                       div_reg[NUM_DIV].quo);
        color_next[15:8]  = blend_chan(left_color_reg[15:8], right_color_reg[15:8],
                                       div_reg[NUM_DIV].quo);
        color_next[7:0]   = blend_chan(left_color_reg[7:0], right_color_reg[7:0],
                                       div_reg[NUM_DIV].quo);
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[LAST]) begin
            color_reg <= color_next;
        end
    end

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = color_reg;

endmodule

`default_nettype wire
